[src/tws_pkg.sv]
package tws_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [5:0] HALVES_TOTAL    = 6'd32;
  localparam logic [5:0] READ_HALF_FIRST = 6'd16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command;
    logic [7:0] write_data;
    logic       io_in;
  } item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       rejected;
  } result_t;

  function automatic logic [7:0] bcd_to_dec(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]} * 8'd10;
    return tens + {4'd0, b[3:0]};
  endfunction

endpackage

[src/three_wire_serial_master.sv]
// Each accepted item's result is registered into the output buffer on acceptance.
// Throughput: one item per cycle while the output buffer is not full; the state
// register update for one half-bit and the result register form a single registered pass.
// A two-entry output buffer lets input continue while one result waits.
// Reset (synchronous, active high) clears all state and empties both output
// entries; the result fields are not cleared, but result_valid stays low.
module three_wire_serial_master (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tws_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output tws_pkg::result_t  result
);

  logic [5:0]  half_bit_count, half_bit_count_next;
  logic [15:0] out_shift, out_shift_next;
  logic [7:0]  in_shift, in_shift_next;
  logic        active, active_next;
  logic        is_read, is_read_next;
  logic [7:0]  last_value, last_value_next;

  logic             accept;
  logic             full;
  logic             done;
  logic             rej;
  logic [5:0]       last_half;
  tws_pkg::result_t res;

  assign item_ready = !full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    half_bit_count_next = half_bit_count;
    out_shift_next      = out_shift;
    in_shift_next       = in_shift;
    active_next         = active;
    is_read_next        = is_read;
    last_value_next     = last_value;
    done                = 1'b0;
    rej                 = 1'b0;
    if (item.opcode == tws_pkg::OP_WRITE || item.opcode == tws_pkg::OP_READ) begin
      if (active) begin
        rej = 1'b1;
      end else begin
        active_next         = 1'b1;
        half_bit_count_next = 6'd0;
        in_shift_next       = 8'd0;
        if (item.opcode == tws_pkg::OP_READ) begin
          is_read_next   = 1'b1;
          out_shift_next = {8'd0, item.command[7:1], 1'b1};
        end else begin
          is_read_next   = 1'b0;
          out_shift_next = {item.write_data, item.command[7:1], 1'b0};
        end
      end
    end else if (item.opcode == tws_pkg::OP_TICK && active) begin
      if (half_bit_count >= tws_pkg::HALVES_TOTAL) begin
        active_next         = 1'b0;
        half_bit_count_next = 6'd0;
        done                = 1'b1;
        if (is_read) begin
          last_value_next = tws_pkg::bcd_to_dec(in_shift);
        end
      end else begin
        if (!half_bit_count[0] && half_bit_count != 6'd0) begin
          out_shift_next = {1'b0, out_shift[15:1]};
        end
        if (!half_bit_count[0] && is_read && half_bit_count >= tws_pkg::READ_HALF_FIRST) begin
          in_shift_next = {item.io_in, in_shift[7:1]};
        end
        half_bit_count_next = half_bit_count + 6'd1;
      end
    end
  end

  assign last_half = half_bit_count_next - 6'd1;

  always_comb begin
    res              = '0;
    res.busy_res     = active_next;
    res.done_res     = done;
    res.read_value   = last_value_next;
    res.rejected     = rej;
    if (active_next) begin
      res.chip_enable = 1'b1;
      if (half_bit_count_next != 6'd0) begin
        res.serial_clock = last_half[0];
        res.io_drive     = !(is_read_next && last_half >= tws_pkg::READ_HALF_FIRST);
      end else begin
        res.io_drive = 1'b1;
      end
      res.io_out = res.io_drive & out_shift_next[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_count <= 6'd0;
      out_shift      <= 16'd0;
      in_shift       <= 8'd0;
      active         <= 1'b0;
      is_read        <= 1'b0;
      last_value     <= 8'd0;
    end else if (accept) begin
      half_bit_count <= half_bit_count_next;
      out_shift      <= out_shift_next;
      in_shift       <= in_shift_next;
      active         <= active_next;
      is_read        <= is_read_next;
      last_value     <= last_value_next;
    end
  end

  tws_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .valid     (result_valid),
    .ready     (result_ready),
    .data      (result)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    half_bit_count <= tws_pkg::HALVES_TOTAL)
    else $error("Half-bit count ran past the end of the transaction.");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !active |-> half_bit_count == 6'd0)
    else $error("Half-bit count nonzero while idle.");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && active && (item.opcode == tws_pkg::OP_WRITE ||
                          item.opcode == tws_pkg::OP_READ))
    |=> active && $stable(half_bit_count) && $stable(out_shift))
    else $error("Rejected start changed the transaction state.");

  a_end_on_tick: assert property (@(posedge clk) disable iff (rst)
    (active && !$past(rst) && !active_next && accept) |-> item.opcode == tws_pkg::OP_TICK)
    else $error("Transaction ended on an item that is not a tick.");

  a_write_keeps_value: assert property (@(posedge clk) disable iff (rst)
    (accept && active && !is_read) |=> $stable(last_value))
    else $error("Write transaction changed the read value.");

endmodule

[src/tws_skid.sv]
module tws_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tws_pkg::result_t  push_data,
  output logic              full,
  output logic              valid,
  input  logic              ready,
  output tws_pkg::result_t  data
);

  logic             skid_valid;
  tws_pkg::result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!valid || ready) begin
        data  <= push_data;
        valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (valid && ready) begin
      if (skid_valid) begin
        data       <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        valid <= 1'b0;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> valid)
    else $error("Skid entry held while the output register is empty.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !ready) |=> skid_valid && $stable(skid_data))
    else $error("Skid entry lost while the output is stalled.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> valid && $stable(data))
    else $error("Stalled result changed.");

endmodule
